// ----- src/umf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umf_pkg
// shared types and constants of the unique mode finder
// ----------------------------------------------------------------------------
package umf_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int MODE_CNT_W  = 7;
  localparam int OUT_DATA_W  = 40;

  // command from the front to the back
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                store;     // value goes into the buffer
    logic                last;      // closes the set
    logic                overflow;  // some value of the set was dropped
  } cmd_t;

endpackage

// ----- src/umf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umf_front
// accepts values and decides store or drop against the buffer depth
// ----------------------------------------------------------------------------
module umf_front #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [umf_pkg::SAMPLE_W-1:0]  s_tdata,
  input  logic                          s_tlast,
  input  logic                          q_full,
  output logic                          q_push,
  output umf_pkg::cmd_t                 q_cmd
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] fill_count;
  logic          dropped_flag;
  logic          store;
  logic          ovf;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && s_tready;
  assign store    = fill_count < CW'(DEPTH);
  assign ovf      = dropped_flag || !store;

  always_comb begin
    q_cmd.sample   = s_tdata;
    q_cmd.store    = store;
    q_cmd.last     = s_tlast;
    q_cmd.overflow = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      dropped_flag <= 1'b0;
    end else if (q_push) begin
      if (s_tlast) begin
        fill_count   <= '0;
        dropped_flag <= 1'b0;
      end else begin
        fill_count   <= fill_count + CW'(store);
        dropped_flag <= ovf;
      end
    end
  end

endmodule

// ----- src/umf_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umf_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module umf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  umf_pkg::cmd_t cmd_in,
  output logic          full,
  input  logic          pop,
  output umf_pkg::cmd_t cmd_out,
  output logic          empty
);

  umf_pkg::cmd_t entry [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign cmd_out = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- src/umf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// umf_back
// buffers the values and scans for the mode when the set closes
// ----------------------------------------------------------------------------
module umf_back #(
  parameter int DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  umf_pkg::cmd_t                   cmd,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [umf_pkg::OUT_DATA_W-1:0]  m_tdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_KEY   = 6'b000010,
    ST_LATCH = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_EVAL  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t                         state;
  logic [umf_pkg::SAMPLE_W-1:0]   mem [DEPTH];
  logic [umf_pkg::SAMPLE_W-1:0]   rd_data;
  logic [AW-1:0]                  rd_addr;
  logic                           mem_we;
  logic [CW-1:0]                  wr_ptr;
  logic [CW-1:0]                  n_vals;
  logic [CW-1:0]                  idx_i;
  logic [CW-1:0]                  idx_j;
  logic [CW-1:0]                  cnt;
  logic [CW-1:0]                  best_cnt;
  logic [umf_pkg::SAMPLE_W-1:0]   best_val;
  logic [umf_pkg::SAMPLE_W-1:0]   key;
  logic                           tie;
  logic                           overflow;
  logic                           match;
  logic                           out_free;
  logic [CW+umf_pkg::MODE_CNT_W-1:0] cnt_ext;

  assign pop      = (state == ST_IDLE) && cmd_valid;
  assign mem_we   = pop && cmd.store;
  assign match    = rd_data == key;
  assign out_free = !m_tvalid || m_tready;
  assign cnt_ext  = {{umf_pkg::MODE_CNT_W{1'b0}}, best_cnt};

  always_comb begin
    case (state)
      ST_KEY:  rd_addr = idx_i[AW-1:0];
      ST_SCAN: rd_addr = idx_j[AW-1:0];
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_ptr[AW-1:0]] <= cmd.sample;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wr_ptr   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (cmd.last) begin
              n_vals   <= wr_ptr + CW'(cmd.store);
              overflow <= cmd.overflow;
              wr_ptr   <= '0;
              idx_i    <= '0;
              best_cnt <= '0;
              best_val <= '0;
              tie      <= 1'b0;
              state    <= ST_KEY;
            end else begin
              wr_ptr <= wr_ptr + CW'(cmd.store);
            end
          end
        end
        ST_KEY: begin
          state <= ST_LATCH;
        end
        ST_LATCH: begin
          key   <= rd_data;
          cnt   <= '0;
          idx_j <= CW'(1);
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          cnt <= cnt + CW'(match);
          if (idx_j == n_vals) begin
            state <= ST_EVAL;
          end else begin
            idx_j <= idx_j + CW'(1);
          end
        end
        ST_EVAL: begin
          if (cnt > best_cnt) begin
            best_cnt <= cnt;
            best_val <= key;
            tie      <= 1'b0;
          end else if (cnt == best_cnt && key != best_val) begin
            tie <= 1'b1;
          end
          idx_i <= idx_i + CW'(1);
          if (idx_i + CW'(1) == n_vals) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_KEY;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tdata  <= {overflow,
                         tie ? {umf_pkg::MODE_CNT_W{1'b0}}
                             : cnt_ext[umf_pkg::MODE_CNT_W-1:0],
                         best_val};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/unique_mode_finder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_mode_finder
// statistical mode of a set of signed 32-bit values, with tie detection
// ----------------------------------------------------------------------------
// values arrive one per transaction on the slave side, tlast closing the set.
// up to DEPTH values are buffered; later ones are dropped and reported as
// overflow. after the closing value one result leaves on the master side:
// the first value to reach the highest occurrence count, that count, or 0
// when another value shares it. values are loaded while the back is idle. the
// scan compares every stored value against the whole buffer through the
// single read port of the value store. the front keeps taking values into a
// two-entry queue while the back scans, until the queue is full, and a
// finished result waits in the output register.
// ----------------------------------------------------------------------------
module unique_mode_finder #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample[31:0]
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // mode_value[31:0], mode_count[38:32], overflow[39]
);

  // commands between the front and the back
  umf_pkg::cmd_t push_cmd;
  umf_pkg::cmd_t pop_cmd;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;

  // front: store or drop decision per transaction
  umf_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // short queue decoupling the two sides
  umf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .cmd_in  (push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .cmd_out (pop_cmd),
    .empty   (q_empty)
  );

  // back: buffer, counting scan and output register
  umf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!q_empty),
    .cmd       (pop_cmd),
    .pop       (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
